>>> sv/skg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skg_pkg
// Shared types and constants for the SEAL 3.0 keystream generator.
// ----------------------------------------------------------------------------
package skg_pkg;

	localparam logic [1:0] CMD_WR_T = 2'd0;
	localparam logic [1:0] CMD_WR_S = 2'd1;
	localparam logic [1:0] CMD_WR_R = 2'd2;
	localparam logic [1:0] CMD_GEN  = 2'd3;

	localparam logic [31:0] IDX_MASK = 32'h0000_07FC;
	localparam int          ROT      = 9;
	localparam int          ITERS    = 64;
	localparam int          STEPS    = 8;

	typedef struct packed {
		logic       start;     // load working regs from seed ^ R (R word already read)
		logic       init_rd;   // T read for init round
		logic       init_upd;  // apply init round
		logic       save_x;    // capture extra regs
		logic       iter_rd;   // T read for iteration step
		logic       iter_upd;  // apply iteration step
		logic       fin_s_rd;  // S read for output
		logic       fin_out;   // combine one S word
		logic       mix;       // post-output extra mix
		logic [1:0] sel;       // word selector
		logic [2:0] step;
		logic       odd;
	} dp_cmd_t;

	function automatic logic [31:0] rotr9(input logic [31:0] x);
		return {x[ROT-1:0], x[31:ROT]};
	endfunction

endpackage
`default_nettype wire

>>> sv/skg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skg_in_if / skg_out_if
// Valid/ready channels for command beats and keystream beats.
// ----------------------------------------------------------------------------
interface skg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [8:0]  table_index;
	logic [31:0] table_word;
	modport source (output valid, cmd, table_index, table_word, input ready);
	modport sink   (input valid, cmd, table_index, table_word, output ready);
endinterface

interface skg_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic [31:0] word_c;
	logic [31:0] word_d;
	logic        last_of_block;
	logic        status;
	modport source (output valid, word_a, word_b, word_c, word_d, last_of_block, status,
		input ready);
	modport sink   (input valid, word_a, word_b, word_c, word_d, last_of_block, status,
		output ready);
endinterface
`default_nettype wire

>>> sv/seal_keystream_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seal_keystream_generator
// A generate beat loads four R words and runs the init rounds, then for each of
// the 64 output beats does eight serial T reads, combines four S words and hands
// the beat off; one T read port sets this pace.
// An exhausted generate gives one beat in the next cycle.
// Reset clears control, counter and output valid; tables stay undefined.
// ----------------------------------------------------------------------------
module seal_keystream_generator #(
	parameter int R_WORDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	skg_in_if.sink           in_ch,
	skg_out_if.source        out_ch
);
	import skg_pkg::*;

	logic [31:0] seed_q;
	dp_cmd_t     c;
	logic        r_rd;
	logic [$clog2(R_WORDS)-1:0] r_addr;
	logic [5:0]  iter;
	logic [31:0] oa, ob, oc, od;
	logic        st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (cfg_we) seed_q <= cfg_wdata;
	end

	skg_ctrl #(.R_WORDS(R_WORDS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_cmd(in_ch.cmd), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_last(out_ch.last_of_block), .out_status(st),
		.c(c), .r_rd, .r_addr, .iter
	);

	skg_datapath #(.R_WORDS(R_WORDS)) u_dp (
		.clk, .c(c),
		.wr_en(in_ch.valid && in_ch.ready && in_ch.cmd != CMD_GEN),
		.wr_cmd(in_ch.cmd), .wr_index(in_ch.table_index), .wr_word(in_ch.table_word),
		.r_rd, .r_addr, .iter, .seed(seed_q),
		.o_a(oa), .o_b(ob), .o_c(oc), .o_d(od)
	);

	assign out_ch.status = st;
	assign out_ch.word_a = st ? 32'd0 : oa;
	assign out_ch.word_b = st ? 32'd0 : ob;
	assign out_ch.word_c = st ? 32'd0 : oc;
	assign out_ch.word_d = st ? 32'd0 : od;

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("ready while beat pending");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |-> out_ch.last_of_block)
		else $error("exhausted beat not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("beat dropped");
endmodule
`default_nettype wire

>>> sv/skg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skg_datapath
// Table memories, working/extra registers and one shared T-lookup unit.
// ----------------------------------------------------------------------------
module skg_datapath #(
	parameter int R_WORDS = 256
) (
	input  wire logic                 clk,
	input  wire skg_pkg::dp_cmd_t     c,
	input  wire logic                 wr_en,
	input  wire logic [1:0]           wr_cmd,
	input  wire logic [8:0]           wr_index,
	input  wire logic [31:0]          wr_word,
	input  wire logic                 r_rd,
	input  wire logic [$clog2(R_WORDS)-1:0] r_addr,
	input  wire logic [5:0]           iter,
	input  wire logic [31:0]          seed,
	output logic [31:0]               o_a,
	output logic [31:0]               o_b,
	output logic [31:0]               o_c,
	output logic [31:0]               o_d
);
	import skg_pkg::*;
	localparam int RW = $clog2(R_WORDS);

	logic [31:0] t_mem [512];
	logic [31:0] s_mem [256];
	logic [31:0] r_mem [R_WORDS];
	logic [31:0] t_rd_q, s_rd_q, r_rd_q;
	logic [31:0] w_q [4];
	logic [31:0] x_q [4];
	logic [8:0]  p_q, q_q;
	logic [31:0] a, b, cc, d;
	logic [1:0]  s_sel;

	always_ff @(posedge clk) begin
		if (wr_en && wr_cmd == CMD_WR_T) t_mem[wr_index] <= wr_word;
		if (wr_en && wr_cmd == CMD_WR_S && !wr_index[8]) s_mem[wr_index[7:0]] <= wr_word;
		if (wr_en && wr_cmd == CMD_WR_R && {23'd0, wr_index} < R_WORDS)
			r_mem[wr_index[RW-1:0]] <= wr_word;
	end

	always_ff @(posedge clk) begin
		if (r_rd) r_rd_q <= r_mem[r_addr];
	end

	logic [8:0] t_addr;
	logic [31:0] pq_sum;
	always_comb begin
		t_addr = w_q[c.sel][10:2];
		pq_sum = 32'd0;
		if (c.iter_rd) begin
			case (c.step)
				3'd0: t_addr = w_q[0][10:2];
				3'd1: t_addr = w_q[1][10:2];
				3'd2: begin pq_sum = {21'd0, p_q, 2'd0} + w_q[2]; t_addr = pq_sum[10:2]; end
				3'd3: begin pq_sum = {21'd0, q_q, 2'd0} + w_q[3]; t_addr = pq_sum[10:2]; end
				3'd4: begin pq_sum = {21'd0, p_q, 2'd0} + w_q[0]; t_addr = pq_sum[10:2]; end
				3'd5: begin pq_sum = {21'd0, q_q, 2'd0} + w_q[1]; t_addr = pq_sum[10:2]; end
				3'd6: begin pq_sum = {21'd0, p_q, 2'd0} + w_q[2]; t_addr = pq_sum[10:2]; end
				default: begin pq_sum = {21'd0, q_q, 2'd0} + w_q[3]; t_addr = pq_sum[10:2]; end
			endcase
		end
	end

	// while combining, fetch the S word for the next output word
	assign s_sel = c.fin_out ? c.sel + 2'd1 : c.sel;

	always_ff @(posedge clk) begin
		if (c.init_rd || c.iter_rd) t_rd_q <= t_mem[t_addr];
		if (c.fin_s_rd) s_rd_q <= s_mem[{iter, s_sel}];
		if (c.iter_rd) begin
			if (c.step[0]) q_q <= t_addr;
			else           p_q <= t_addr;
		end
	end

	assign a = w_q[0]; assign b = w_q[1]; assign cc = w_q[2]; assign d = w_q[3];

	always_ff @(posedge clk) begin
		if (c.start) begin
			w_q[c.sel] <= r_rd_q ^ ((seed >> (8 * c.sel)) | (seed << (32 - 8 * c.sel)));
		end else if (c.init_upd) begin
			w_q[c.sel + 2'd1] <= w_q[c.sel + 2'd1] + t_rd_q;
			w_q[c.sel]        <= rotr9(w_q[c.sel]);
		end else if (c.save_x) begin
			x_q[0] <= d; x_q[1] <= b; x_q[2] <= a; x_q[3] <= cc;
		end else if (c.iter_upd) begin
			case (c.step)
				3'd0: begin w_q[1] <= (b + t_rd_q) ^ rotr9(a); w_q[0] <= rotr9(a); end
				3'd1: begin w_q[2] <= (cc ^ t_rd_q) + rotr9(b); w_q[1] <= rotr9(b); end
				3'd2: begin w_q[3] <= (d + t_rd_q) ^ rotr9(cc); w_q[2] <= rotr9(cc); end
				3'd3: begin w_q[0] <= (a ^ t_rd_q) + rotr9(d); w_q[3] <= rotr9(d); end
				3'd4: begin w_q[1] <= b ^ t_rd_q; w_q[0] <= rotr9(a); end
				3'd5: begin w_q[2] <= cc + t_rd_q; w_q[1] <= rotr9(b); end
				3'd6: begin w_q[3] <= d ^ t_rd_q; w_q[2] <= rotr9(cc); end
				default: begin w_q[0] <= a + t_rd_q; w_q[3] <= rotr9(d); end
			endcase
		end else if (c.fin_out) begin
			case (c.sel)
				2'd0: o_a <= b + s_rd_q;
				2'd1: o_b <= cc ^ s_rd_q;
				2'd2: o_c <= d + s_rd_q;
				default: o_d <= a ^ s_rd_q;
			endcase
		end else if (c.mix) begin
			w_q[0] <= a + x_q[c.odd ? 2 : 0];
			w_q[1] <= b + x_q[c.odd ? 3 : 1];
			w_q[2] <= cc ^ x_q[c.odd ? 2 : 0];
			w_q[3] <= d ^ x_q[c.odd ? 3 : 1];
		end
	end
endmodule
`default_nettype wire

>>> sv/skg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skg_ctrl
// Sequencer: block start, init rounds, 64 iterations, beat hand-off.
// ----------------------------------------------------------------------------
module skg_ctrl #(
	parameter int R_WORDS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_cmd,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            out_last,
	output logic            out_status,
	output skg_pkg::dp_cmd_t c,
	output logic            r_rd,
	output logic [$clog2(R_WORDS)-1:0] r_addr,
	output logic [5:0]      iter
);
	import skg_pkg::*;
	localparam int RW = $clog2(R_WORDS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RREAD = 9'b000000010,
		ST_LOAD  = 9'b000000100,
		ST_IRD   = 9'b000001000,
		ST_IUPD  = 9'b000010000,
		ST_TRD   = 9'b000100000,
		ST_TUPD  = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

	state_t      st_q;
	logic [6:0]  blk_q;
	logic [1:0]  sub_q;
	logic [1:0]  pass_q;
	logic [2:0]  step_q;
	logic [5:0]  it_q;
	logic        exh_q;
	logic [9:0]  need;

	assign need = {1'b0, blk_q, 2'b00} + 10'd4;
	assign in_ready = (st_q == ST_IDLE);
	assign iter = it_q;
	assign out_valid = (st_q == ST_WAIT);
	assign out_status = exh_q;
	assign out_last = exh_q || (it_q == 6'd63);
	assign r_rd = (st_q == ST_RREAD);
	assign r_addr = RW'({blk_q, sub_q});

	always_comb begin
		c = '0;
		c.sel = sub_q;
		c.step = step_q;
		c.odd = it_q[0];
		case (st_q)
			ST_LOAD: c.start = 1'b1;
			ST_IRD:  c.init_rd = 1'b1;
			ST_IUPD: begin
				c.init_upd = 1'b1;
			end
			ST_TRD:  c.iter_rd = 1'b1;
			ST_TUPD: c.iter_upd = 1'b1;
			ST_OUT:  begin c.fin_out = 1'b1; end
			default: ;
		endcase
		if (st_q == ST_TUPD && step_q == 3'd7) c.fin_s_rd = 1'b1;
		if (st_q == ST_OUT && sub_q != 2'd3) c.fin_s_rd = 1'b1;
		if (st_q == ST_WAIT && out_ready && !exh_q) c.mix = 1'b1;
		// extra regs captured once the second pass is done
		if (st_q == ST_IRD && pass_q == 2'd2 && sub_q == 2'd0) c.save_x = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; blk_q <= '0; sub_q <= '0; pass_q <= '0;
			step_q <= '0; it_q <= '0; exh_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (in_valid && in_cmd == CMD_GEN) begin
					sub_q <= '0;
					if ({22'd0, need} > R_WORDS) begin
						exh_q <= 1'b1; st_q <= ST_WAIT;
					end else begin
						exh_q <= 1'b0; st_q <= ST_RREAD;
					end
				end
				ST_RREAD: st_q <= ST_LOAD;
				ST_LOAD: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin pass_q <= '0; st_q <= ST_IRD; end
					else st_q <= ST_RREAD;
				end
				ST_IRD: st_q <= ST_IUPD;
				ST_IUPD: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						pass_q <= pass_q + 2'd1;
						if (pass_q == 2'd2) begin
							st_q <= ST_TRD; step_q <= '0; it_q <= '0;
							blk_q <= blk_q + 7'd1;
						end else st_q <= ST_IRD;
					end else st_q <= ST_IRD;
				end
				ST_TRD: st_q <= ST_TUPD;
				ST_TUPD: begin
					step_q <= step_q + 3'd1;
					sub_q <= '0;
					st_q <= (step_q == 3'd7) ? ST_OUT : ST_TRD;
				end
				ST_OUT: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) st_q <= ST_WAIT;
				end
				ST_WAIT: if (out_ready) begin
					if (exh_q || it_q == 6'd63) st_q <= ST_IDLE;
					else begin it_q <= it_q + 6'd1; step_q <= '0; st_q <= ST_TRD; end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
